FILE: rtl/core/sbf_pkg.sv
// Shared constants, types and helpers for the separable binomial 5x5 filter.
`default_nettype none

package sbf_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 4;

    // Field and register widths
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;
    localparam int SAMPLE_W = 17;
    localparam int ROWSUM_W = 21;
    localparam int RESULT_W = 25;

    // Position counters; row runs up to height + 2 for the tail
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 3);

    // Row store: one word per column, one lane per row mod 4
    localparam int LANES  = 4;
    localparam int LANE_W = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register indexes (byte address bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Which of the four outer taps of a 5-tap filter fall inside the image
    typedef struct packed {
        logic m2;
        logic m1;
        logic p1;
        logic p2;
    } t_taps;

    // One classified word handed from front to back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;     // zero for drain words and words past the frame
        logic                       have_row;  // row filter output is in the frame
        logic                       have_col;  // a result is due
        logic                       frame_end; // result is the last pixel
        t_taps                      h_taps;    // horizontal taps
        t_taps                      v_taps;    // vertical taps
        logic [LANE_W-1:0]          lane;      // row mod 4 of the row filter pixel
        logic [COL_W-1:0]           column;    // column of the row filter pixel
    } t_work;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] v);
        logic [WIDTH_W-1:0] r;
        if (int'(v) < MIN_DIM) begin
            r = WIDTH_W'(MIN_DIM);
        end else if (int'(v) > MAX_WIDTH) begin
            r = WIDTH_W'(MAX_WIDTH);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] v);
        logic [HEIGHT_W-1:0] r;
        if (int'(v) < MIN_DIM) begin
            r = HEIGHT_W'(MIN_DIM);
        end else if (int'(v) > MAX_HEIGHT) begin
            r = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sbf_front.sv
// Front end: accepts words, tracks frame position and classifies each word.
`default_nettype none

module sbf_front import sbf_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_command,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample,
    input  wire logic [WIDTH_W-1:0]          i_width,
    input  wire logic [HEIGHT_W-1:0]         i_height,
    input  wire logic                        i_restart,
    input  wire logic                        i_queue_full,
    output logic                             o_push,
    output t_work                            o_work
);

    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ROW_W-1:0]   h_ext;
    logic [ROW_W-1:0]   p_row;
    logic [WIDTH_W-1:0] col_ext;
    logic [WIDTH_W-1:0] p_col;
    logic               accept;
    logic               in_pixels;
    logic               counted;
    logic               last_col;
    logic               wrap;

    assign h_ext   = ROW_W'(i_height);
    assign col_ext = WIDTH_W'(r_col);

    // Early drain words are taken and dropped
    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign in_pixels  = r_row < h_ext;
    assign counted    = (i_command == CMD_PIXEL) || !in_pixels;
    assign o_push     = accept && counted;

    // Position of the pixel two words back; row wraps high at frame start
    always_comb begin
        if (r_col >= COL_W'(2)) begin
            p_row = r_row;
            p_col = col_ext - WIDTH_W'(2);
        end else begin
            p_row = r_row - ROW_W'(1);
            p_col = col_ext + i_width - WIDTH_W'(2);
        end
    end

    // Classification
    always_comb begin
        o_work.value     = (i_command == CMD_PIXEL && in_pixels) ? i_sample : '0;
        o_work.have_row  = p_row < h_ext;
        o_work.have_col  = (p_row >= ROW_W'(2)) && (p_row <= h_ext + ROW_W'(1));
        o_work.frame_end = (p_row == h_ext + ROW_W'(1)) && (p_col == i_width - WIDTH_W'(1));
        o_work.h_taps.m2 = p_col >= WIDTH_W'(2);
        o_work.h_taps.m1 = p_col >= WIDTH_W'(1);
        o_work.h_taps.p1 = p_col <= i_width - WIDTH_W'(2);
        o_work.h_taps.p2 = p_col <= i_width - WIDTH_W'(3);
        o_work.v_taps.m2 = p_row >= ROW_W'(4);
        o_work.v_taps.m1 = p_row >= ROW_W'(3);
        o_work.v_taps.p1 = p_row <= h_ext;
        o_work.v_taps.p2 = p_row < h_ext;
        o_work.lane      = p_row[LANE_W-1:0];
        o_work.column    = p_col[COL_W-1:0];
    end

    // Raster position; tail ends at column 1 of the third row past the frame
    assign last_col = col_ext == i_width - WIDTH_W'(1);
    assign wrap     = (r_row == h_ext + ROW_W'(2)) && (r_col == COL_W'(1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (wrap) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_ext < i_width)
        else $error("column counter past image width");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= h_ext + ROW_W'(2))
        else $error("row counter past frame tail");

    a_end_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_work.frame_end |-> o_work.have_col)
        else $error("frame end flagged on a word without a result");

endmodule

`default_nettype wire

FILE: rtl/core/sbf_queue.sv
// Short queue of classified words between front and back.
`default_nettype none

module sbf_queue import sbf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_work i_work,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_work      o_head
);

    t_work              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_slots[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_work;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill level out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("word pushed into a full queue");

endmodule

`default_nettype wire

FILE: rtl/core/sbf_back.sv
// Back end: row filter, four-row store, column filter and output register.
`default_nettype none

module sbf_back import sbf_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_head_valid,
    input  wire t_work                       i_head,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [RESULT_W-1:0]       o_filtered,
    output logic                             o_frame_end
);

    // Lane offset from the oldest stored row of the column window
    localparam logic [LANE_W-1:0] OFF_UP2 = 2'd0;
    localparam logic [LANE_W-1:0] OFF_UP1 = 2'd1;
    localparam logic [LANE_W-1:0] OFF_MID = 2'd2;
    localparam logic [LANE_W-1:0] OFF_DN1 = 2'd3;

    logic signed [SAMPLE_W-1:0]   r_win [4];
    logic                         r_s1_valid;
    t_work                        r_s1;
    logic signed [ROWSUM_W-1:0]   r_s1_sum;
    logic [LANES*ROWSUM_W-1:0]    r_rd;
    logic [LANES*ROWSUM_W-1:0]    r_store [MAX_WIDTH];
    logic                         r_out_valid;
    logic signed [RESULT_W-1:0]   r_filtered;
    logic                         r_frame_end;

    logic signed [ROWSUM_W-1:0]   tap_p2, tap_p1, tap_mid, tap_m1, tap_m2;
    logic signed [ROWSUM_W-1:0]   row_sum;
    logic signed [RESULT_W-1:0]   lane_ext  [LANES];
    logic signed [RESULT_W-1:0]   lane_term [LANES];
    logic [LANE_W-1:0]            lane_off  [LANES];
    logic signed [RESULT_W-1:0]   new_term;
    logic signed [RESULT_W-1:0]   col_sum;
    logic [LANES*ROWSUM_W-1:0]    store_wdata;
    logic                         out_free;
    logic                         s1_adv;
    logic                         store_we;

    // Flow control
    assign out_free = !r_out_valid || i_out_ready;
    assign s1_adv   = r_s1_valid && (!r_s1.have_col || out_free);
    assign o_pop    = i_head_valid && (!r_s1_valid || s1_adv);
    assign store_we = s1_adv && r_s1.have_row;

    // Row filter over the window after the incoming word shifts in
    assign tap_p2  = ROWSUM_W'(i_head.value);
    assign tap_p1  = ROWSUM_W'(r_win[0]);
    assign tap_mid = ROWSUM_W'(r_win[1]);
    assign tap_m1  = ROWSUM_W'(r_win[2]);
    assign tap_m2  = ROWSUM_W'(r_win[3]);

    assign row_sum = (i_head.h_taps.p2 ? tap_p2 : '0)
                   + (i_head.h_taps.p1 ? (tap_p1 <<< 2) : '0)
                   + (tap_mid <<< 2) + (tap_mid <<< 1)
                   + (i_head.h_taps.m1 ? (tap_m1 <<< 2) : '0)
                   + (i_head.h_taps.m2 ? tap_m2 : '0);

    // Column filter: weight each stored lane by its row offset
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_ext[l] = RESULT_W'($signed(r_rd[l*ROWSUM_W +: ROWSUM_W]));
            lane_off[l] = LANE_W'(l) - r_s1.lane;
            unique case (lane_off[l])
                OFF_UP2: lane_term[l] = r_s1.v_taps.m2 ? lane_ext[l] : '0;
                OFF_UP1: lane_term[l] = r_s1.v_taps.m1 ? (lane_ext[l] <<< 2) : '0;
                OFF_MID: lane_term[l] = (lane_ext[l] <<< 2) + (lane_ext[l] <<< 1);
                OFF_DN1: lane_term[l] = r_s1.v_taps.p1 ? (lane_ext[l] <<< 2) : '0;
                default: lane_term[l] = '0;
            endcase
        end
    end

    assign new_term = r_s1.v_taps.p2 ? RESULT_W'(r_s1_sum) : '0;
    assign col_sum  = lane_term[0] + lane_term[1] + lane_term[2] + lane_term[3] + new_term;

    // Write back the column word with this row's lane replaced
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            store_wdata[l*ROWSUM_W +: ROWSUM_W] = (LANE_W'(l) == r_s1.lane)
                ? r_s1_sum : r_rd[l*ROWSUM_W +: ROWSUM_W];
        end
    end

    // Row store, registered read
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_store[i_head.column];
        end
        if (store_we) begin
            r_store[r_s1.column] <= store_wdata;
        end
    end

    // Control state and sample window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win       <= '{default: '0};
        end else begin
            if (o_pop) begin
                r_win[0] <= i_head.value;
                r_win[1] <= r_win[0];
                r_win[2] <= r_win[1];
                r_win[3] <= r_win[2];
            end
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && r_s1.have_col) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1     <= i_head;
            r_s1_sum <= row_sum;
        end
        if (s1_adv && r_s1.have_col) begin
            r_filtered  <= col_sum;
            r_frame_end <= r_s1.frame_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

FILE: rtl/core/separable_binomial_5x5_filter_core.sv
// Top level of the separable 5x5 binomial filter: config registers and wiring.
// Throughput: one word per cycle while the output is ready, set by the row store
//   doing one read and one write-back per word through a read port and a separate
//   write port. Result path: a pixel's result is completed by the word that comes
//   2*width+2 counted words later, then passes the stage and output registers.
// Reset (synchronous, active low): width and height return to 1024, the frame
//   position and sample window clear; the row store is not cleared.
`default_nettype none

module separable_binomial_5x5_filter_core import sbf_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input words
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_command,
    input  wire logic signed [SAMPLE_W-1:0]  i_sample,
    // result words
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [RESULT_W-1:0]       o_filtered,
    output logic                             o_frame_end,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [APB_ADDR_W-1:0]       paddr,
    input  wire logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]            prdata,
    output logic                             pready
);

    logic [WIDTH_W-1:0]  r_image_width;
    logic [HEIGHT_W-1:0] r_image_height;
    logic                cfg_we;
    logic                reg_index;
    logic [WIDTH_W-1:0]  width_used;
    logic [HEIGHT_W-1:0] height_used;
    logic                queue_full;
    logic                push;
    t_work               push_work;
    logic                head_valid;
    t_work               head_work;
    logic                pop;

    // Register port
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign reg_index = paddr[APB_ADDR_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= WIDTH_W'(1024);
            r_image_height <= HEIGHT_W'(1024);
        end else if (cfg_we) begin
            unique case (reg_index)
                REG_WIDTH:  r_image_width  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: r_image_height <= pwdata[HEIGHT_W-1:0];
                default:    r_image_width  <= r_image_width;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_WIDTH:  prdata = APB_DATA_W'(r_image_width);
            REG_HEIGHT: prdata = APB_DATA_W'(r_image_height);
            default:    prdata = '0;
        endcase
    end

    assign width_used  = clamp_width(r_image_width);
    assign height_used = clamp_height(r_image_height);

    sbf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_sample     (i_sample),
        .i_width      (width_used),
        .i_height     (height_used),
        .i_restart    (cfg_we),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_work       (push_work)
    );

    sbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head_work)
    );

    sbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_work),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_filtered   (o_filtered),
        .o_frame_end  (o_frame_end)
    );

endmodule

`default_nettype wire
